[sv/primality_test_64_macros.svh]
`ifndef PRIMALITY_TEST_64_MACROS_SVH
`define PRIMALITY_TEST_64_MACROS_SVH

// implication checked on the next clock
`define PRIM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prim check failed");

// implication checked on the next clock, also while reset is held
`define PRIM_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("prim check failed");

// property that must hold at every clock
`define PRIM_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("prim check failed");

`endif

[sv/prim_pkg.sv]
package prim_pkg;

  localparam logic [63:0] SMALL_PRIME_MASK = 64'd2891462833508853932;
  localparam logic [63:0] ODD_PRIME_PROD   = 64'd16294579238595022365;

  typedef struct packed {
    logic [63:0] number;
    logic        need_mr;
    logic        verdict;
  } prim_entry_t;

endpackage

[sv/prim_front.sv]
module prim_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          in_number,
  output logic                 push,
  output prim_pkg::prim_entry_t push_entry,
  input  logic                 full
);
  import prim_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GCD  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]  state;
  logic [63:0] gx, gy;
  prim_entry_t entry;

  assign in_ready   = (state == ST_IDLE);
  assign push       = (state == ST_PUSH) && !full;
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            entry.number  <= in_number;
            entry.need_mr <= 1'b0;
            if (in_number[63:6] == 58'd0) begin
              entry.verdict <= SMALL_PRIME_MASK[in_number[5:0]];
              state <= ST_PUSH;
            end else if (!in_number[0]) begin
              entry.verdict <= 1'b0;
              state <= ST_PUSH;
            end else begin
              entry.verdict <= 1'b0;
              gx <= in_number;
              gy <= ODD_PRIME_PROD;
              state <= ST_GCD;
            end
          end
        end
        ST_GCD: begin
          // binary gcd, one shift or one subtract per cycle; gx always stays odd
          if (gy == 64'd0) begin
            entry.need_mr <= (gx == 64'd1);
            state <= ST_PUSH;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (gx > gy) begin
            gx <= gy;
            gy <= gx - gy;
          end else begin
            gy <= gy - gx;
          end
        end
        ST_PUSH: begin
          if (!full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/prim_fifo.sv]
module prim_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  prim_pkg::prim_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output prim_pkg::prim_entry_t head
);
  import prim_pkg::*;

  prim_entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

endmodule

[sv/prim_back.sv]
module prim_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  prim_pkg::prim_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_prime
);
  import prim_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TZ    = 3'd1;
  localparam logic [2:0] ST_BASE  = 3'd2;
  localparam logic [2:0] ST_POW_A = 3'd3;
  localparam logic [2:0] ST_POW_B = 3'd4;
  localparam logic [2:0] ST_CHK   = 3'd5;
  localparam logic [2:0] ST_MUL   = 3'd6;

  localparam logic [1:0] DST_ACC = 2'd0;
  localparam logic [1:0] DST_B   = 2'd1;
  localparam logic [1:0] DST_X   = 2'd2;

  function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [63:0] room;
    room = m - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

  function automatic logic [30:0] base_of(input logic [2:0] i);
    case (i)
      3'd0:    return 31'd2;
      3'd1:    return 31'd325;
      3'd2:    return 31'd9375;
      3'd3:    return 31'd28178;
      3'd4:    return 31'd450775;
      3'd5:    return 31'd9780504;
      3'd6:    return 31'd1795265022;
      default: return 31'd0;
    endcase
  endfunction

  logic [2:0]  state, ret;
  logic [63:0] m, m1, d, acc, b, e, x;
  logic [5:0]  s, r;
  logic [2:0]  idx;
  logic [63:0] mx, my, mac;
  logic [5:0]  mcnt;
  logic [1:0]  mdst;
  logic [63:0] mac_dbl, mac_next;

  assign pop = (state == ST_IDLE) && !empty && !out_valid;

  always_comb begin
    mac_dbl  = add_mod(mac, mac, m);
    mac_next = my[63] ? add_mod(mac_dbl, mx, m) : mac_dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (head.need_mr) begin
              m  <= head.number;
              m1 <= head.number - 64'd1;
              d  <= head.number - 64'd1;
              s  <= 6'd0;
              state <= ST_TZ;
            end else begin
              out_prime <= head.verdict;
              out_valid <= 1'b1;
            end
          end
        end
        ST_TZ: begin
          // m is odd and above 64, so m-1 is even and nonzero
          if (!d[0]) begin
            d <= d >> 1;
            s <= s + 6'd1;
          end else begin
            idx   <= 3'd0;
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          if (idx == 3'd7 || m <= {33'd0, base_of(idx)}) begin
            out_prime <= 1'b1;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            acc   <= 64'd1;
            b     <= {33'd0, base_of(idx)};
            e     <= d;
            state <= ST_POW_A;
          end
        end
        ST_POW_A: begin
          if (e == 64'd0) begin
            x     <= acc;
            r     <= 6'd1;
            state <= ST_CHK;
          end else if (e[0]) begin
            mx <= acc; my <= b; mac <= 64'd0; mcnt <= 6'd63;
            mdst <= DST_ACC; ret <= ST_POW_B;
            state <= ST_MUL;
          end else begin
            state <= ST_POW_B;
          end
        end
        ST_POW_B: begin
          mx <= b; my <= b; mac <= 64'd0; mcnt <= 6'd63;
          mdst <= DST_B; ret <= ST_POW_A;
          e <= e >> 1;
          state <= ST_MUL;
        end
        ST_CHK: begin
          // a 1 only passes straight out of the power; one reached by squaring does not
          if ((x == 64'd1 && r == 6'd1) || x == m1) begin
            idx   <= idx + 3'd1;
            state <= ST_BASE;
          end else if (r >= s) begin
            out_prime <= 1'b0;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            mx <= x; my <= x; mac <= 64'd0; mcnt <= 6'd63;
            mdst <= DST_X; ret <= ST_CHK;
            r <= r + 6'd1;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          // shift-add modular multiply, one multiplier bit per cycle, msb first
          mac <= mac_next;
          my  <= my << 1;
          if (mcnt == 6'd0) begin
            case (mdst)
              DST_ACC: acc <= mac_next;
              DST_B:   b   <= mac_next;
              default: x   <= mac_next;
            endcase
            state <= ret;
          end
          mcnt <= mcnt - 6'd1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/primality_test_64.sv]
// Words below 64 or even are classified at once; other words get a gcd with the odd
// primes 3 to 53, then up to seven strong-probable-prime bases of modular multiplies.
// The serial modular multiplier in the back end limits throughput; the front end
// classifies the next word while the back end works.
// Reset: synchronous, active-high rst clears FSMs and FIFO pointers; no clearing pass.
module primality_test_64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] number
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] prime flag, [7:1] zero
);
  import prim_pkg::*;

  logic        push, full, pop, empty, prime_flag;
  prim_entry_t push_entry, head;

  prim_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_number(s_tdata),
    .push(push), .push_entry(push_entry), .full(full)
  );

  prim_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .push_entry(push_entry), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  prim_back u_back (
    .clk(clk), .rst(rst),
    .empty(empty), .head(head), .pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_prime(prime_flag)
  );

  assign m_tdata = {7'd0, prime_flag};

endmodule

[sv/prim_chk.sv]
`include "primality_test_64_macros.svh"

module prim_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  `PRIM_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))
  `PRIM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `PRIM_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)
  `PRIM_ASSERT_NOW(a_pad_zero, m_tdata[7:1] == 7'd0 || !m_tvalid)
  `PRIM_ASSERT_NEXT_RST(a_reset_quiet, rst, !m_tvalid)

endmodule

bind primality_test_64 prim_chk u_chk (.*);

[tb/tb_primality_test_64.sv]
`timescale 1ns / 1ps

module tb_primality_test_64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [63:0] number
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] prime flag, [7:1] zero

  localparam logic [63:0] PRIME_MASK_LOW = 64'd2891462833508853932;
  localparam logic [63:0] ODD_PROD_3_53  = 64'd16294579238595022365;
  localparam int          N_RANDOM       = 76;
  localparam int          STALL_LIMIT    = 400000;

  typedef struct {
    logic [63:0] number;
    logic        known;   // verdict typed into the table
    logic        verdict;
  } vec_t;

  bit          verdicts_due[$];
  logic [63:0] numbers_due[$];
  int          n_errors = 0;
  int          n_sent = 0;
  int          n_seen = 0;
  int          n_primes = 0;
  bit          sending_done = 0;
  bit          long_hold = 0;
  int          idle_cycles = 0;

  primality_test_64 DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] p;
    p = a * b;
    return 64'(p % m);
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 1;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b, m);
      b = mulmod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic bit prime_verdict(logic [63:0] v);
    logic [63:0] witnesses [7];
    logic [63:0] m1, d, x;
    int s, r;
    bit ok;
    witnesses = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
                  64'd1795265022};
    if (v < 64) return PRIME_MASK_LOW[v[5:0]];
    if (!v[0]) return 0;
    if (gcd64(v, ODD_PROD_3_53) != 1) return 0;
    m1 = v - 1;
    s = 0;
    d = m1;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < 7; i++) begin
      if (v <= witnesses[i]) return 1;
      x = powmod(witnesses[i], d, v);
      if (x == 1) continue;
      r = 1;
      ok = 0;
      while (!ok) begin
        if (x == m1) ok = 1;
        else if (r >= s) return 0;
        else begin
          x = mulmod(x, x, v);
          r++;
        end
      end
    end
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] num, int got, int want);
    $display("mismatch %s: number %0d got %0d want %0d", what, num, got, want);
    n_errors++;
  endtask

  task automatic offer_word(logic [63:0] v, logic known, logic verdict);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    numbers_due.push_back(v);
    verdicts_due.push_back(known ? verdict : prime_verdict(v));
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  function automatic logic [63:0] random_number();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = v | 64'd1;
      2: v = {v[63:1], 1'b1} >> $urandom_range(0, 40);
      3: v = 64'($urandom_range(0, 200));
      default: ;
    endcase
    return v;
  endfunction

  // sender
  initial begin
    vec_t dir [$];
    dir = '{
      '{64'd0, 1, 0}, '{64'd1, 1, 0}, '{64'd2, 1, 1}, '{64'd3, 1, 1},
      '{64'd61, 1, 1}, '{64'd63, 1, 0}, '{64'd64, 1, 0}, '{64'd67, 1, 1},
      '{64'd65, 1, 0}, '{64'd2809, 1, 0}, '{64'd3481, 0, 0},
      '{64'd341, 0, 0}, '{64'd2047, 0, 0}, '{64'd3215031751, 0, 0},
      '{64'd9780503, 0, 0}, '{64'd1795265021, 0, 0},
      '{64'd1000000007, 0, 0}, '{64'd18446744073709551557, 0, 0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 0, 0}, '{64'hFFFF_FFFF_FFFF_FFFE, 1, 0},
      '{64'h8000_0000_0000_0001, 0, 0}, '{64'h5555_5555_5555_5555, 0, 0},
      '{64'hAAAA_AAAA_AAAA_AAAB, 0, 0}, '{64'd4611686018427387847, 0, 0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (dir[i]) offer_word(dir[i].number, dir[i].known, dir[i].verdict);
    long_hold = 1;
    for (int i = 0; i < N_RANDOM; i++) offer_word(random_number(), 0, 0);
    s_tvalid <= 1'b0;
    sending_done = 1;
  end

  // receiver, with one long hold-off while the sender keeps offering
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        m_tready <= 1'b0;
        repeat (2000) @(posedge clk);
      end
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_seen++;
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected word", 64'd0, m_tdata, -1);
      end else begin
        if (m_tdata[0] != verdicts_due[0])
          report_mismatch("prime flag", numbers_due[0], m_tdata[0], verdicts_due[0]);
        if (m_tdata[7:1] != 7'd0)
          report_mismatch("pad bits", numbers_due[0], m_tdata[7:1], 0);
        if (verdicts_due[0]) n_primes++;
        void'(verdicts_due.pop_front());
        void'(numbers_due.pop_front());
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", verdicts_due.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    wait (sending_done && verdicts_due.size() == 0);
    repeat (200) @(posedge clk);
    $display("tested %0d numbers (%0d prime): small table, evens, shared factors,",
             n_sent, n_primes);
    $display("full strong-probable-prime runs, with a long output stall");
    if (n_errors == 0 && verdicts_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
